// ----- design/closed_curve_signed_area_defines.svh -----
// ----------------------------------------------------------------------------
// closed_curve_signed_area assertion macros
// Shared concurrent assertion forms, clocked on aclk and off during reset.
// ----------------------------------------------------------------------------
`ifndef CLOSED_CURVE_SIGNED_AREA_DEFINES_SVH
`define CLOSED_CURVE_SIGNED_AREA_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define CCSA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define CCSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ccsa_pkg.sv -----
// ----------------------------------------------------------------------------
// ccsa_pkg
// Types, constants and the arctangent table for the curve area block.
// ----------------------------------------------------------------------------
package ccsa_pkg;

    localparam int COORD_W = 32;
    localparam int RAD_W   = 31;
    localparam int TOL_W   = 16;
    localparam int AREA_W  = 64;
    localparam int ANG_W   = 35;   // doubled end angle needs 34 bits plus margin
    localparam int SC_W    = 36;   // q2.30 sine and cosine with growth
    localparam int QBITS   = 6;    // quadrant count of a reduced angle
    localparam int TAB_N   = 32;

    localparam logic [63:0] HALF_PI_Q56 = 64'h01921FB54442D184;
    localparam logic signed [SC_W-1:0] CORDIC_GAIN = 36'sd652032874;

    typedef enum logic {
        SEG_LINE = 1'b0,
        SEG_ARC  = 1'b1
    } seg_kind_t;

    typedef struct packed {
        seg_kind_t                  kind;
        logic signed [COORD_W-1:0]  start_x;
        logic signed [COORD_W-1:0]  start_y;
        logic signed [COORD_W-1:0]  end_x;
        logic signed [COORD_W-1:0]  end_y;
        logic signed [COORD_W-1:0]  center_y;
        logic [RAD_W-1:0]           radius;
        logic signed [COORD_W-1:0]  start_angle;
        logic signed [COORD_W-1:0]  sweep_angle;
        logic                       last;
        logic                       closed;
        logic                       vertical;
    } seg_t;

    typedef struct packed {
        logic                   done;
        logic signed [SC_W-1:0] cos_v;
        logic signed [SC_W-1:0] sin_v;
    } cs_res_t;

    typedef struct packed {
        logic                done;
        logic signed [127:0] prod;
    } mul_res_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_RED,
        CS_SIGN,
        CS_FOLD,
        CS_ROT
    } cs_state_t;

    typedef enum logic [1:0] {
        MU_IDLE,
        MU_ACC,
        MU_NEG
    } mul_state_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_PREP,
        BK_CS_GO,
        BK_CS_WAIT,
        BK_MUL_GO,
        BK_MUL_WAIT,
        BK_TERM,
        BK_ACC
    } bk_state_t;

    typedef logic signed [63:0] atan_tab_t [TAB_N];

    // atan(2^-i) in q8.56 from its power series, long division done bit by bit
    function automatic atan_tab_t atan_table();
        atan_tab_t   tab;
        logic [63:0] acc;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] rem;
        logic [63:0] quo;
        int          e;
        for (int i = 0; i < TAB_N; i++) begin
            if (i == 0) begin
                tab[i] = $signed(HALF_PI_Q56 >> 1);
            end else begin
                acc = '0;
                for (int n = 0; n < TAB_N; n++) begin
                    if (i * (2 * n + 1) <= 62) begin
                        e   = 62 - i * (2 * n + 1);
                        num = 64'd1 << e;
                        den = 64'(2 * n + 1);
                        rem = '0;
                        quo = '0;
                        for (int k = 63; k >= 0; k--) begin
                            rem = {rem[62:0], num[k]};
                            if (rem >= den) begin
                                rem    = rem - den;
                                quo[k] = 1'b1;
                            end
                        end
                        acc = (n % 2 == 1) ? acc - quo : acc + quo;
                    end
                end
                tab[i] = $signed(acc) >>> 6;
            end
        end
        return tab;
    endfunction

endpackage

// ----- design/ccsa_front.sv -----
// ----------------------------------------------------------------------------
// ccsa_front
// Takes segment items, unpacks them, flags near-vertical lines and holds
// them in a two-entry queue for the back end. Also holds the tolerance.
// ----------------------------------------------------------------------------
module ccsa_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [255:0]                    s_tdata,
    input  logic [0:0]                      s_tuser,
    input  logic                            s_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ccsa_pkg::TOL_W-1:0]      cfg_data,
    output ccsa_pkg::seg_t                  item,
    output logic                            item_valid,
    input  logic                            pop
);

    logic [ccsa_pkg::TOL_W-1:0] tol_reg;
    ccsa_pkg::seg_t             q_mem [2];
    logic                       wr_ptr_reg;
    logic                       rd_ptr_reg;
    logic [1:0]                 cnt_reg;
    logic [1:0]                 cnt_next;
    logic                       push;
    ccsa_pkg::seg_t             seg_in;
    logic signed [32:0]         dx;
    logic [32:0]                adx;

    assign cfg_ready  = 1'b1;
    assign s_tready   = (cnt_reg != 2'd2);
    assign push       = s_tvalid && s_tready;
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = q_mem[rd_ptr_reg];

    always_comb begin
        dx  = {s_tdata[95], s_tdata[95:64]} - {s_tdata[31], s_tdata[31:0]};
        adx = dx[32] ? 33'(-dx) : 33'(dx);
        seg_in.kind        = ccsa_pkg::seg_kind_t'(s_tuser[0]);
        seg_in.start_x     = s_tdata[31:0];
        seg_in.start_y     = s_tdata[63:32];
        seg_in.end_x       = s_tdata[95:64];
        seg_in.end_y       = s_tdata[127:96];
        seg_in.center_y    = s_tdata[159:128];
        seg_in.radius      = s_tdata[190:160];
        seg_in.start_angle = s_tdata[222:191];
        seg_in.sweep_angle = s_tdata[254:223];
        seg_in.closed      = s_tdata[255];
        seg_in.last        = s_tlast;
        // a zero tolerance never marks a line vertical
        seg_in.vertical    = (adx < {17'd0, tol_reg});
    end

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg    <= ccsa_pkg::TOL_W'(1);
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                tol_reg <= cfg_data;
            end
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= seg_in;
        end
    end

endmodule

// ----- design/ccsa_cordic.sv -----
// ----------------------------------------------------------------------------
// ccsa_cordic
// Iterative sine and cosine of a q7.28 angle: quadrant reduction by
// shift-subtract, then rotation-mode steps, then quadrant restore.
// ----------------------------------------------------------------------------
module ccsa_cordic #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [ccsa_pkg::ANG_W-1:0]   angle,
    output ccsa_pkg::cs_res_t                   res
);

    localparam ccsa_pkg::atan_tab_t ATAN_TAB = ccsa_pkg::atan_table();
    localparam logic signed [63:0] QUARTER = $signed(ccsa_pkg::HALF_PI_Q56 >> 1);

    ccsa_pkg::cs_state_t            state_reg;
    ccsa_pkg::cs_state_t            state_next;
    logic [63:0]                    rem_reg;
    logic                           neg_reg;
    logic [ccsa_pkg::QBITS-1:0]     quo_reg;
    logic [2:0]                     k_reg;
    logic signed [63:0]             z_reg;
    logic [1:0]                     q_reg;
    logic signed [ccsa_pkg::SC_W-1:0] x_reg;
    logic signed [ccsa_pkg::SC_W-1:0] y_reg;
    logic [4:0]                     i_reg;
    logic                           done_reg;
    logic signed [ccsa_pkg::SC_W-1:0] cos_reg;
    logic signed [ccsa_pkg::SC_W-1:0] sin_reg;

    logic signed [63:0]             a_full;
    logic [63:0]                    h_shift;
    logic                           red_take;
    logic signed [63:0]             z_signed;
    logic signed [ccsa_pkg::SC_W-1:0] nx;
    logic signed [ccsa_pkg::SC_W-1:0] ny;
    logic signed [63:0]             nz;
    logic                           load_angle;
    logic                           red_last;
    logic                           rot_last;

    assign res.done  = done_reg;
    assign res.cos_v = cos_reg;
    assign res.sin_v = sin_reg;

    always_comb begin
        a_full   = {{(64 - ccsa_pkg::ANG_W){angle[ccsa_pkg::ANG_W-1]}}, angle} <<< 28;
        h_shift  = ccsa_pkg::HALF_PI_Q56 << k_reg;
        red_take = (rem_reg >= h_shift);
        z_signed = neg_reg ? -$signed(rem_reg) : $signed(rem_reg);
        if (z_reg >= 0) begin
            nx = x_reg - (y_reg >>> i_reg);
            ny = y_reg + (x_reg >>> i_reg);
            nz = z_reg - ATAN_TAB[i_reg];
        end else begin
            nx = x_reg + (y_reg >>> i_reg);
            ny = y_reg - (x_reg >>> i_reg);
            nz = z_reg + ATAN_TAB[i_reg];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ccsa_pkg::CS_IDLE: if (start) state_next = ccsa_pkg::CS_RED;
            ccsa_pkg::CS_RED:  if (k_reg == 3'd0) state_next = ccsa_pkg::CS_SIGN;
            ccsa_pkg::CS_SIGN: state_next = ccsa_pkg::CS_FOLD;
            ccsa_pkg::CS_FOLD: state_next = ccsa_pkg::CS_ROT;
            ccsa_pkg::CS_ROT: begin
                if (i_reg == 5'(CORDIC_STEPS - 1)) state_next = ccsa_pkg::CS_IDLE;
            end
            default: state_next = ccsa_pkg::CS_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        load_angle = (state_reg == ccsa_pkg::CS_IDLE) && start;
        red_last   = (state_reg == ccsa_pkg::CS_RED) && (k_reg == 3'd0);
        rot_last   = (state_reg == ccsa_pkg::CS_ROT) && (i_reg == 5'(CORDIC_STEPS - 1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ccsa_pkg::CS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= rot_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_angle) begin
            rem_reg <= a_full[63] ? 64'(-a_full) : 64'(a_full);
            neg_reg <= a_full[63];
            quo_reg <= '0;
            k_reg   <= 3'(ccsa_pkg::QBITS - 1);
        end
        if (state_reg == ccsa_pkg::CS_RED) begin
            if (red_take) begin
                rem_reg        <= rem_reg - h_shift;
                quo_reg[k_reg] <= 1'b1;
            end
            if (!red_last) begin
                k_reg <= k_reg - 3'd1;
            end
        end
        if (state_reg == ccsa_pkg::CS_SIGN) begin
            z_reg <= z_signed;
            q_reg <= neg_reg ? 2'(-quo_reg) : quo_reg[1:0];
        end
        if (state_reg == ccsa_pkg::CS_FOLD) begin
            // bring the residue into plus or minus an eighth turn
            if (z_reg > QUARTER) begin
                z_reg <= z_reg - $signed(ccsa_pkg::HALF_PI_Q56);
                q_reg <= q_reg + 2'd1;
            end else if (z_reg < -QUARTER) begin
                z_reg <= z_reg + $signed(ccsa_pkg::HALF_PI_Q56);
                q_reg <= q_reg - 2'd1;
            end
            x_reg <= ccsa_pkg::CORDIC_GAIN;
            y_reg <= '0;
            i_reg <= 5'd0;
        end
        if (state_reg == ccsa_pkg::CS_ROT) begin
            x_reg <= nx;
            y_reg <= ny;
            z_reg <= nz;
            i_reg <= i_reg + 5'd1;
        end
        if (rot_last) begin
            case (q_reg)
                2'd0: begin cos_reg <= nx;  sin_reg <= ny;  end
                2'd1: begin cos_reg <= -ny; sin_reg <= nx;  end
                2'd2: begin cos_reg <= -nx; sin_reg <= -ny; end
                default: begin cos_reg <= ny; sin_reg <= -nx; end
            endcase
        end
    end

endmodule

// ----- design/ccsa_mul.sv -----
// ----------------------------------------------------------------------------
// ccsa_mul
// Signed 64 by 64 multiplier giving 128 bits: one 32 by 32 partial product
// a cycle on the magnitudes, then the sign is applied.
// ----------------------------------------------------------------------------
module ccsa_mul (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [63:0]  a,
    input  logic signed [63:0]  b,
    output ccsa_pkg::mul_res_t  res
);

    ccsa_pkg::mul_state_t state_reg;
    ccsa_pkg::mul_state_t state_next;
    logic [63:0]          ua_reg;
    logic [63:0]          ub_reg;
    logic                 sgn_reg;
    logic [127:0]         acc_reg;
    logic [1:0]           cnt_reg;
    logic                 done_reg;
    logic signed [127:0]  prod_reg;

    logic [31:0]          op_a;
    logic [31:0]          op_b;
    logic [63:0]          pp;
    logic [127:0]         pp_sh;
    logic                 load;
    logic                 fin;

    assign res.done = done_reg;
    assign res.prod = prod_reg;

    always_comb begin
        op_a = cnt_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
        op_b = cnt_reg[0] ? ub_reg[63:32] : ub_reg[31:0];
        pp   = op_a * op_b;
        case (cnt_reg)
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ccsa_pkg::MU_IDLE: if (start) state_next = ccsa_pkg::MU_ACC;
            ccsa_pkg::MU_ACC:  if (cnt_reg == 2'd3) state_next = ccsa_pkg::MU_NEG;
            ccsa_pkg::MU_NEG:  state_next = ccsa_pkg::MU_IDLE;
            default:           state_next = ccsa_pkg::MU_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        load = (state_reg == ccsa_pkg::MU_IDLE) && start;
        fin  = (state_reg == ccsa_pkg::MU_NEG);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ccsa_pkg::MU_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ua_reg  <= a[63] ? 64'(-a) : 64'(a);
            ub_reg  <= b[63] ? 64'(-b) : 64'(b);
            sgn_reg <= a[63] ^ b[63];
            acc_reg <= '0;
            cnt_reg <= 2'd0;
        end
        if (state_reg == ccsa_pkg::MU_ACC) begin
            acc_reg <= acc_reg + pp_sh;
            cnt_reg <= cnt_reg + 2'd1;
        end
        if (fin) begin
            prod_reg <= sgn_reg ? -$signed(acc_reg) : $signed(acc_reg);
        end
    end

endmodule

// ----- design/ccsa_back.sv -----
// ----------------------------------------------------------------------------
// ccsa_back
// Sequencer that works out one segment's area term with the shared CORDIC
// and multiplier, adds it to the saturating sum and emits the curve area.
// ----------------------------------------------------------------------------
`include "closed_curve_signed_area_defines.svh"

module ccsa_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  ccsa_pkg::seg_t                      item,
    input  logic                                item_valid,
    output logic                                pop,
    output logic                                cs_start,
    output logic signed [ccsa_pkg::ANG_W-1:0]   cs_angle,
    input  ccsa_pkg::cs_res_t                   cs_res,
    output logic                                mul_start,
    output logic signed [63:0]                  mul_a,
    output logic signed [63:0]                  mul_b,
    input  ccsa_pkg::mul_res_t                  mul_res,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ccsa_pkg::AREA_W-1:0]         m_area,
    output logic                                m_saturated
);

    localparam logic signed [63:0] S64_MIN = {1'b1, 63'd0};
    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};

    ccsa_pkg::bk_state_t            state_reg;
    ccsa_pkg::bk_state_t            state_next;
    ccsa_pkg::seg_t                 cur_reg;
    logic signed [32:0]             dx_reg;
    logic signed [32:0]             sy_reg;
    logic signed [ccsa_pkg::ANG_W-1:0] alpha_reg;
    logic signed [ccsa_pkg::ANG_W-1:0] beta_reg;
    logic [1:0]                     cs_idx_reg;
    logic [1:0]                     mu_idx_reg;
    logic signed [ccsa_pkg::SC_W-1:0] ca_reg;
    logic signed [ccsa_pkg::SC_W-1:0] cb_reg;
    logic signed [ccsa_pkg::SC_W-1:0] s2a_reg;
    logic signed [ccsa_pkg::SC_W-1:0] s2b_reg;
    logic signed [63:0]             p1_reg;
    logic signed [63:0]             p2_reg;
    logic signed [127:0]            t1_reg;
    logic signed [127:0]            t2_reg;
    logic signed [63:0]             term_reg;
    logic                           term_ovf_reg;
    logic signed [63:0]             sum_reg;
    logic                           sat_reg;
    logic                           m_valid_reg;
    logic [63:0]                    out_area_reg;
    logic                           out_sat_reg;

    logic                           is_arc;
    logic signed [ccsa_pkg::SC_W:0] dcos;
    logic signed [39:0]             sweep_f;
    logic signed [127:0]            pre;
    logic                           in_range;
    logic signed [63:0]             term_val;
    logic signed [63:0]             sum_raw;
    logic                           add_ovf;
    logic signed [63:0]             sum_new;
    logic                           flag_new;
    logic                           out_free;
    logic                           load_out;
    logic                           acc_done;

    assign is_arc      = (cur_reg.kind == ccsa_pkg::SEG_ARC);
    assign m_tvalid    = m_valid_reg;
    assign m_area      = out_area_reg;
    assign m_saturated = out_sat_reg;
    assign out_free    = !m_valid_reg || m_tready;

    // operand selection for the angle unit and the multiplier
    always_comb begin
        case (cs_idx_reg)
            2'd0:    cs_angle = alpha_reg;
            2'd1:    cs_angle = beta_reg;
            2'd2:    cs_angle = alpha_reg <<< 1;
            default: cs_angle = beta_reg <<< 1;
        endcase
        dcos    = ca_reg - cb_reg;
        dcos    = -dcos;
        sweep_f = (40'(cur_reg.sweep_angle) <<< 3) - (40'(s2b_reg) - 40'(s2a_reg));
        if (!is_arc) begin
            mul_a = 64'(sy_reg);
            mul_b = 64'(dx_reg);
        end else begin
            case (mu_idx_reg)
                2'd0: begin
                    mul_a = {33'd0, cur_reg.radius};
                    mul_b = 64'(cur_reg.center_y);
                end
                2'd1: begin
                    mul_a = p1_reg;
                    mul_b = 64'(dcos);
                end
                2'd2: begin
                    mul_a = {33'd0, cur_reg.radius};
                    mul_b = {33'd0, cur_reg.radius};
                end
                default: begin
                    mul_a = p2_reg;
                    mul_b = 64'(sweep_f);
                end
            endcase
        end
    end

    // term reduction to q32.32 with clamp
    always_comb begin
        if (is_arc) begin
            pre = ((t1_reg <<< 2) - t2_reg) >>> 32;
        end else begin
            pre = t1_reg >>> 1;
        end
        in_range = (&pre[127:63]) || !(|pre[127:63]);
        if (!is_arc && cur_reg.vertical) begin
            term_val = '0;
        end else if (in_range) begin
            term_val = pre[63:0];
        end else begin
            term_val = pre[127] ? S64_MIN : S64_MAX;
        end
    end

    always_comb begin
        sum_raw  = sum_reg + term_reg;
        add_ovf  = (sum_reg[63] == term_reg[63]) && (sum_raw[63] != sum_reg[63]);
        sum_new  = add_ovf ? (sum_reg[63] ? S64_MIN : S64_MAX) : sum_raw;
        flag_new = sat_reg || term_ovf_reg || add_ovf;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ccsa_pkg::BK_IDLE: if (item_valid) state_next = ccsa_pkg::BK_PREP;
            ccsa_pkg::BK_PREP: begin
                if (is_arc) begin
                    state_next = ccsa_pkg::BK_CS_GO;
                end else if (cur_reg.vertical) begin
                    state_next = ccsa_pkg::BK_TERM;
                end else begin
                    state_next = ccsa_pkg::BK_MUL_GO;
                end
            end
            ccsa_pkg::BK_CS_GO: state_next = ccsa_pkg::BK_CS_WAIT;
            ccsa_pkg::BK_CS_WAIT: begin
                if (cs_res.done) begin
                    state_next = (cs_idx_reg == 2'd3) ? ccsa_pkg::BK_MUL_GO
                                                      : ccsa_pkg::BK_CS_GO;
                end
            end
            ccsa_pkg::BK_MUL_GO: state_next = ccsa_pkg::BK_MUL_WAIT;
            ccsa_pkg::BK_MUL_WAIT: begin
                if (mul_res.done) begin
                    state_next = (!is_arc || mu_idx_reg == 2'd3) ? ccsa_pkg::BK_TERM
                                                                 : ccsa_pkg::BK_MUL_GO;
                end
            end
            ccsa_pkg::BK_TERM: state_next = ccsa_pkg::BK_ACC;
            ccsa_pkg::BK_ACC:  if (acc_done) state_next = ccsa_pkg::BK_IDLE;
            default:           state_next = ccsa_pkg::BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        pop       = (state_reg == ccsa_pkg::BK_IDLE) && item_valid;
        cs_start  = (state_reg == ccsa_pkg::BK_CS_GO);
        mul_start = (state_reg == ccsa_pkg::BK_MUL_GO);
        load_out  = (state_reg == ccsa_pkg::BK_ACC) && cur_reg.last && out_free;
        acc_done  = (state_reg == ccsa_pkg::BK_ACC) && (!cur_reg.last || out_free);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ccsa_pkg::BK_IDLE;
            sum_reg     <= '0;
            sat_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (acc_done) begin
                // the last segment hands the sum out and starts a fresh curve
                sum_reg <= cur_reg.last ? 64'sd0 : sum_new;
                sat_reg <= cur_reg.last ? 1'b0 : flag_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= item;
        end
        if (state_reg == ccsa_pkg::BK_PREP) begin
            dx_reg     <= 33'(cur_reg.end_x) - 33'(cur_reg.start_x);
            sy_reg     <= 33'(cur_reg.start_y) + 33'(cur_reg.end_y);
            alpha_reg  <= ccsa_pkg::ANG_W'(cur_reg.start_angle);
            beta_reg   <= ccsa_pkg::ANG_W'(cur_reg.start_angle)
                        + ccsa_pkg::ANG_W'(cur_reg.sweep_angle);
            cs_idx_reg <= 2'd0;
            mu_idx_reg <= 2'd0;
        end
        if (state_reg == ccsa_pkg::BK_CS_WAIT && cs_res.done) begin
            case (cs_idx_reg)
                2'd0:    ca_reg  <= cs_res.cos_v;
                2'd1:    cb_reg  <= cs_res.cos_v;
                2'd2:    s2a_reg <= cs_res.sin_v;
                default: s2b_reg <= cs_res.sin_v;
            endcase
            cs_idx_reg <= cs_idx_reg + 2'd1;
        end
        if (state_reg == ccsa_pkg::BK_MUL_WAIT && mul_res.done) begin
            if (!is_arc) begin
                t1_reg <= mul_res.prod;
            end else begin
                case (mu_idx_reg)
                    2'd0:    p1_reg <= mul_res.prod[63:0];
                    2'd1:    t1_reg <= mul_res.prod;
                    2'd2:    p2_reg <= mul_res.prod[63:0];
                    default: t2_reg <= mul_res.prod;
                endcase
            end
            mu_idx_reg <= mu_idx_reg + 2'd1;
        end
        if (state_reg == ccsa_pkg::BK_TERM) begin
            term_reg     <= term_val;
            term_ovf_reg <= !(!is_arc && cur_reg.vertical) && !in_range;
        end
        if (load_out) begin
            if (!cur_reg.closed) begin
                out_area_reg <= '0;
                out_sat_reg  <= flag_new;
            end else if (sum_new == S64_MIN) begin
                out_area_reg <= S64_MAX;
                out_sat_reg  <= 1'b1;
            end else begin
                out_area_reg <= 64'(-sum_new);
                out_sat_reg  <= flag_new;
            end
        end
    end

    `CCSA_ASSERT_SAME(a_pop_nonempty, pop, item_valid, "item taken from an empty queue")
    `CCSA_ASSERT_SAME(a_one_unit, mul_start, !cs_start, "both arithmetic units started at once")
    `CCSA_ASSERT_SAME(a_cs_waited, cs_res.done, state_reg == ccsa_pkg::BK_CS_WAIT,
        "angle result with no request pending")
    `CCSA_ASSERT_NEXT(a_emit_clears, load_out, m_tvalid && (sum_reg == 64'sd0) && !sat_reg,
        "curve sum not cleared when its area went out")

endmodule

// ----- design/closed_curve_signed_area.sv -----
// ----------------------------------------------------------------------------
// closed_curve_signed_area
// Signed area of a curve made of line and arc segments, one segment an item.
// ----------------------------------------------------------------------------
// An arc takes longer than a line: the single iterative CORDIC runs the four
// angles in turn and the 32x32 multiplier needs four passes for each of the
// four arc products. A two-entry queue in front takes items while the back
// end works and a finished area waits in the output register. The area comes
// out on the item marked tlast, negated so counterclockwise is positive, or
// zero when the curve is flagged open; the running sum then clears. No
// clearing pass after reset.
module closed_curve_signed_area #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_x, start_y, end_x, end_y, center_y, radius, start_angle,
    // sweep_angle, curve_closed
    input  logic [255:0] s_tdata,
    // seg_kind
    input  logic [0:0]   s_tuser,
    input  logic         s_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data,
    output logic         m_tvalid,
    input  logic         m_tready,
    // area, saturated, zero pad
    output logic [71:0]  m_tdata
);

    ccsa_pkg::seg_t                    item;
    logic                              item_valid;
    logic                              pop;
    logic                              cs_start;
    logic signed [ccsa_pkg::ANG_W-1:0] cs_angle;
    ccsa_pkg::cs_res_t                 cs_res;
    logic                              mul_start;
    logic signed [63:0]                mul_a;
    logic signed [63:0]                mul_b;
    ccsa_pkg::mul_res_t                mul_res;
    logic [63:0]                       area;
    logic                              saturated;

    assign m_tdata = {7'd0, saturated, area};

    ccsa_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .item       (item),
        .item_valid (item_valid),
        .pop        (pop)
    );

    ccsa_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cs_start),
        .angle   (cs_angle),
        .res     (cs_res)
    );

    ccsa_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .res     (mul_res)
    );

    ccsa_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item        (item),
        .item_valid  (item_valid),
        .pop         (pop),
        .cs_start    (cs_start),
        .cs_angle    (cs_angle),
        .cs_res      (cs_res),
        .mul_start   (mul_start),
        .mul_a       (mul_a),
        .mul_b       (mul_b),
        .mul_res     (mul_res),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_area      (area),
        .m_saturated (saturated)
    );

endmodule

// ----- dv/ccsa_checker.sv -----
// ----------------------------------------------------------------------------
// ccsa_checker
// Watches the segment, register and area channels of the curve area block,
// predicts the area of every curve from the accepted segments and compares
// each area item with the oldest prediction.
// ----------------------------------------------------------------------------
module ccsa_checker #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [255:0] s_tdata,
    input  logic [0:0]   s_tuser,
    input  logic         s_tlast,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [15:0]  cfg_data,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [71:0]  m_tdata,
    output int           fail_count,
    output int           areas_pending
);

    typedef struct {
        logic [63:0] area;
        logic        sat;
    } area_item_t;

    localparam longint HALF_PI  = longint'(ccsa_pkg::HALF_PI_Q56);
    localparam longint AREA_MAX = 64'sh7FFFFFFFFFFFFFFF;
    localparam longint AREA_MIN = 64'sh8000000000000000;

    area_item_t   area_q[$];
    longint       atan_q56[32];
    logic [15:0]  tol;
    logic [63:0]  run_sum;
    logic         run_sat;

    initial begin
        longint acc;
        longint t;
        for (int i = 0; i < 32; i++) begin
            if (i == 0) begin
                atan_q56[i] = HALF_PI / 2;
            end else begin
                acc = 0;
                for (int n = 0; i * (2 * n + 1) <= 62; n++) begin
                    t = longint'((64'd1 << (62 - i * (2 * n + 1))) / 64'(2 * n + 1));
                    acc = (n % 2 == 1) ? acc - t : acc + t;
                end
                atan_q56[i] = acc >>> 6;
            end
        end
    end

    // q4.28 angle to q2.30 cosine and sine
    function automatic void sin_cos(input longint ang, output longint c, output longint s);
        longint a;
        longint q;
        longint z;
        longint x;
        longint y;
        longint nx;
        a = ang * 268435456;
        q = a / HALF_PI;
        z = a - q * HALF_PI;
        x = longint'(ccsa_pkg::CORDIC_GAIN);
        y = 0;
        if (z > HALF_PI / 2) begin
            z -= HALF_PI;
            q++;
        end else if (z < -(HALF_PI / 2)) begin
            z += HALF_PI;
            q--;
        end
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= atan_q56[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += atan_q56[i];
            end
            x = nx;
        end
        case (q[1:0])
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic logic [63:0] clamp64(input logic signed [127:0] v, inout logic flag);
        logic signed [127:0] lo;
        logic signed [127:0] hi;
        lo = AREA_MIN;
        hi = AREA_MAX;
        if (v < lo) begin
            flag = 1'b1;
            return AREA_MIN;
        end
        if (v > hi) begin
            flag = 1'b1;
            return AREA_MAX;
        end
        return v[63:0];
    endfunction

    function automatic logic [63:0] segment_area(input logic [255:0] d,
                                                 input ccsa_pkg::seg_kind_t kind,
                                                 inout logic flag);
        longint x0, y0, x1, y1, dx, adx;
        longint cy, r, alpha, swp, beta;
        longint ca, sa, cb, sb, c2a, s2a, c2b, s2b;
        logic signed [127:0] f1, f2, w;
        x0 = longint'($signed(d[31:0]));
        y0 = longint'($signed(d[63:32]));
        x1 = longint'($signed(d[95:64]));
        y1 = longint'($signed(d[127:96]));
        cy = longint'($signed(d[159:128]));
        r  = longint'({33'd0, d[190:160]});
        alpha = longint'($signed(d[222:191]));
        swp   = longint'($signed(d[254:223]));
        if (kind == ccsa_pkg::SEG_LINE) begin
            dx  = x1 - x0;
            adx = dx < 0 ? -dx : dx;
            if (adx < longint'({48'd0, tol}))
                return 64'd0;
            f1 = y0 + y1;
            f2 = dx;
            return clamp64((f1 * f2) >>> 1, flag);
        end
        beta = alpha + swp;
        sin_cos(alpha, ca, sa);
        sin_cos(beta, cb, sb);
        sin_cos(2 * alpha, c2a, s2a);
        sin_cos(2 * beta, c2b, s2b);
        f1 = r * cy;
        f2 = cb - ca;
        w  = (f1 * f2) <<< 2;
        f1 = r * r;
        f2 = swp * 8 - (s2b - s2a);
        w  = w - f1 * f2;
        return clamp64(w >>> 32, flag);
    endfunction

    always @(posedge aclk) begin
        logic        flag;
        logic [63:0] term;
        logic [63:0] total;
        area_item_t  want;
        if (!aresetn) begin
            tol        = 16'd1;
            run_sum    = '0;
            run_sat    = 1'b0;
            fail_count = 0;
            area_q.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                tol = cfg_data;
            if (s_tvalid && s_tready) begin
                flag  = run_sat;
                term  = segment_area(s_tdata, ccsa_pkg::seg_kind_t'(s_tuser[0]), flag);
                total = run_sum + term;
                if (run_sum[63] == term[63] && total[63] != run_sum[63]) begin
                    flag  = 1'b1;
                    total = run_sum[63] ? AREA_MIN : AREA_MAX;
                end
                run_sum = total;
                run_sat = flag;
                if (s_tlast) begin
                    want.area = '0;
                    if (s_tdata[255]) begin
                        if (run_sum == AREA_MIN) begin
                            flag      = 1'b1;
                            want.area = AREA_MAX;
                        end else begin
                            want.area = -run_sum;
                        end
                    end
                    want.sat = flag;
                    area_q.push_back(want);
                    run_sum = '0;
                    run_sat = 1'b0;
                end
            end
            if (m_tvalid && m_tready) begin
                if (area_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected area item %h sat %b", $time,
                             m_tdata[63:0], m_tdata[64]);
                end else begin
                    want = area_q.pop_front();
                    if (m_tdata[63:0] !== want.area) begin
                        fail_count++;
                        $display("%0t: area expected %h actual %h", $time, want.area,
                                 m_tdata[63:0]);
                    end
                    if (m_tdata[64] !== want.sat) begin
                        fail_count++;
                        $display("%0t: saturated expected %b actual %b", $time, want.sat,
                                 m_tdata[64]);
                    end
                end
            end
        end
        areas_pending = area_q.size();
    end

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives curves of line and arc segments into the curve area block under
// several vertical tolerances, with random gaps and stalls on both sides and
// one long output stall; the checker predicts and compares every area.
// ----------------------------------------------------------------------------
module tb;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [255:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         s_tlast;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [15:0]  cfg_data;
    logic         m_tvalid;
    logic         m_tready;
    logic [71:0]  m_tdata;
    int           fail_count;
    int           areas_pending;
    int           rx_cycle;

    closed_curve_signed_area dut (.*);

    ccsa_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #60000000;
        $display("TEST FAILED");
        $finish;
    end

    // receiver: short and long stalls, quiet stretches, one long hold-off
    initial begin
        int gap;
        bit quiet;
        m_tready = 1'b0;
        rx_cycle = 0;
        gap      = 0;
        quiet    = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            rx_cycle++;
            if (rx_cycle % 400 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (rx_cycle >= 3000 && rx_cycle < 9000) begin
                m_tready <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'($urandom);
            3: return 32'($urandom_range(0, 15)) - 32'd8;
            default: return 32'($urandom_range(0, 32'h01FFFFFF)) - 32'h01000000;
        endcase
    endfunction

    function automatic logic [255:0] make_seg(logic [31:0] x0, logic [31:0] y0,
                                              logic [31:0] x1, logic [31:0] y1,
                                              logic [31:0] cy, logic [30:0] r,
                                              logic [31:0] a0, logic [31:0] sw,
                                              logic closed);
        return {closed, sw, a0, r, cy, y1, x1, y0, x0};
    endfunction

    function automatic logic [255:0] random_seg();
        logic [30:0] r;
        logic [31:0] a0;
        logic [31:0] sw;
        case ($urandom_range(0, 7))
            0: r = 31'h7FFFFFFF;
            1: r = 31'($urandom);
            2: r = '0;
            default: r = 31'($urandom_range(0, 32'h00FFFFFF));
        endcase
        a0 = ($urandom_range(0, 5) == 0) ? 32'($urandom)
                                         : 32'($urandom_range(0, 32'h6487ED50)) - 32'h3243F6A8;
        sw = ($urandom_range(0, 5) == 0) ? 32'($urandom)
                                         : 32'($urandom_range(0, 32'h6487ED50)) - 32'h3243F6A8;
        return make_seg(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                        pick_coord(), r, a0, sw, $urandom_range(0, 7) != 0);
    endfunction

    // valid stays up after the handshake; the next item, a gap or the
    // caller takes it down at the same falling edge
    task automatic send_seg(input ccsa_pkg::seg_kind_t kind, input logic [255:0] d,
                            input logic last);
        int gap;
        if ($urandom_range(0, 2) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120)
                                              : $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= kind;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic set_tolerance(input logic [15:0] v);
        s_tvalid <= 1'b0;
        while (areas_pending != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_curves(input int n_items);
        int left;
        int len;
        left = n_items;
        while (left > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
            if (len > left)
                len = left;
            for (int k = 0; k < len; k++)
                send_seg(ccsa_pkg::seg_kind_t'($urandom_range(0, 1)), random_seg(),
                         k == len - 1);
            left -= len;
        end
    endtask

    initial begin
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        aresetn   = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset tolerance: vertical line and a unit step
        send_seg(ccsa_pkg::SEG_LINE, make_seg(32'd5, 32'd100, 32'd5, 32'd900,
                                              0, 0, 0, 0, 1), 0);
        send_seg(ccsa_pkg::SEG_LINE, make_seg(32'd5, 32'd100, 32'd6, 32'd900,
                                              0, 0, 0, 0, 1), 1);
        // sum of -(2^63 - 2^31), near the most negative value, then negated
        send_seg(ccsa_pkg::SEG_LINE, make_seg(32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                                              32'h80000000, 0, 0, 0, 0, 1), 1);
        // large positive term, just below the clamp
        send_seg(ccsa_pkg::SEG_LINE, make_seg(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                              32'h7FFFFFFF, 0, 0, 0, 0, 1), 1);
        // sum overflow over two terms, then an open curve still flagged
        send_seg(ccsa_pkg::SEG_LINE, make_seg(32'h80000000, 32'h60000000, 32'h7FFFFFFF,
                                              32'h60000000, 0, 0, 0, 0, 1), 0);
        send_seg(ccsa_pkg::SEG_LINE, make_seg(32'h80000000, 32'h60000000, 32'h7FFFFFFF,
                                              32'h60000000, 0, 0, 0, 0, 0), 1);
        // full circle, unit radius, centre on the axis
        send_seg(ccsa_pkg::SEG_ARC, make_seg(0, 0, 0, 0, 0, 31'h10000, 0,
                                             32'h6487ED51, 1), 1);
        // arc extremes: zero radius, largest radius and angles
        send_seg(ccsa_pkg::SEG_ARC, make_seg(0, 0, 0, 0, 32'h7FFFFFFF, 0, 32'h7FFFFFFF,
                                             32'h80000000, 1), 1);
        send_seg(ccsa_pkg::SEG_ARC, make_seg(0, 0, 0, 0, 32'h80000000, 31'h7FFFFFFF,
                                             32'h80000000, 32'h80000000, 1), 1);
        send_seg(ccsa_pkg::SEG_ARC, make_seg(0, 0, 0, 0, 32'h7FFFFFFF, 31'h7FFFFFFF,
                                             32'h7FFFFFFF, 32'h7FFFFFFF, 1), 1);
        // unit square outline with a half-circle arc for its right side, closed
        send_seg(ccsa_pkg::SEG_LINE, make_seg(0, 0, 32'h10000, 0, 0, 0, 0, 0, 1), 0);
        send_seg(ccsa_pkg::SEG_ARC, make_seg(0, 0, 0, 0, 32'h8000, 31'h8000, 32'hE6DE04AC,
                                             32'h3243F6A8, 1), 0);
        send_seg(ccsa_pkg::SEG_LINE, make_seg(32'h10000, 32'h10000, 0, 32'h10000,
                                              0, 0, 0, 0, 1), 1);
        random_curves(250);

        set_tolerance(16'd0);
        send_seg(ccsa_pkg::SEG_LINE, make_seg(32'd7, 32'd3, 32'd7, 32'd9, 0, 0, 0, 0, 1), 1);
        random_curves(450);

        set_tolerance(16'hFFFF);
        send_seg(ccsa_pkg::SEG_LINE, make_seg(0, 32'd3, 32'hFFFE, 32'd9, 0, 0, 0, 0, 1), 0);
        send_seg(ccsa_pkg::SEG_LINE, make_seg(0, 32'd3, 32'hFFFF, 32'd9, 0, 0, 0, 0, 1), 1);
        random_curves(450);

        set_tolerance(16'($urandom));
        random_curves(350);

        set_tolerance(16'($urandom_range(0, 255)));
        random_curves(380);

        s_tvalid <= 1'b0;
        while (areas_pending != 0) @(negedge aclk);
        repeat (400) @(negedge aclk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/ccsa_pkg.sv
design/ccsa_front.sv
design/ccsa_cordic.sv
design/ccsa_mul.sv
design/ccsa_back.sv
design/closed_curve_signed_area.sv
dv/ccsa_checker.sv
dv/tb.sv
